// ===== design/kap_pkg.sv =====
// Shared types, constants and helper functions of the keypad alarm panel controller.
package kap_pkg;

   localparam int CODE_W      = 14;
   localparam int TICK_W      = 8;
   localparam int SEC_W       = 5;
   localparam int BLINK_W     = 4;
   localparam int DIGIT_CNT_W = 2;
   localparam int OP_W        = 2;
   localparam int KEY_W       = 8;
   localparam int SW_W        = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 14;
   localparam int MAX_CODES   = 4;

   localparam logic [OP_W-1:0] OP_KEY    = 2'd0;
   localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
   localparam logic [OP_W-1:0] OP_SWITCH = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_ARM_DELAY   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENTRY_DELAY = 3'd5;

   localparam logic [KEY_W-1:0] KEY_ZERO = 8'h30;
   localparam logic [KEY_W-1:0] KEY_NINE = 8'h39;
   localparam logic [KEY_W-1:0] KEY_HASH = 8'h23;

   localparam logic [SW_W-1:0] FRONT_DOOR_MASK   = 8'b0000_0001;
   localparam logic [SW_W-1:0] OTHER_SWITCH_MASK = 8'b1111_1110;

   localparam logic [TICK_W-1:0]  DELAY_RESET  = 8'd100;
   localparam logic [BLINK_W-1:0] BLINK_PERIOD = 4'd10;
   localparam logic [DIGIT_CNT_W-1:0] LAST_DIGIT = 2'd3;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'd0,
      MODE_ARMING = 3'd1,
      MODE_ARMED  = 3'd2,
      MODE_ENTRY  = 3'd3,
      MODE_ALARM  = 3'd4
   } mode_type;

   typedef struct packed {
      logic [TICK_W-1:0] arm_ticks;
      logic [TICK_W-1:0] entry_ticks;
   } delay_cfg_type;

   typedef struct packed {
      mode_type         mode;
      logic [SEC_W-1:0] seconds_left;
      logic             countdown_shown;
      logic             alarm_lamp;
      logic             code_accepted;
   } result_type;

   // Divide by ten through the reciprocal 205/2048, exact for every 8-bit value.
   function automatic logic [SEC_W-1:0] div10(input logic [TICK_W-1:0] x);
      logic [15:0] prod;
      prod = 16'(x) * 16'd205;
      return prod[15:11];
   endfunction

   function automatic logic multiple_of_ten(input logic [TICK_W-1:0] x);
      logic [TICK_W-1:0] back;
      back = 8'(div10(x)) * 8'd10;
      return back == x;
   endfunction

   // Place value of a digit; the first digit typed is the thousands digit.
   function automatic logic [CODE_W-1:0] digit_value(input logic [DIGIT_CNT_W-1:0] pos,
                                                     input logic [3:0] digit);
      logic [CODE_W-1:0] value;
      case (pos)
         2'd0:    value = 14'(digit) * 14'd1000;
         2'd1:    value = 14'(digit) * 14'd100;
         2'd2:    value = 14'(digit) * 14'd10;
         default: value = 14'(digit);
      endcase
      return value;
   endfunction

endpackage

// ===== design/kap_cfg.sv =====
// Configuration registers: the valid codes and the two countdown lengths.
module kap_cfg #(
   parameter int NUM_CODES = 4
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_write_enable,
   input  logic [kap_pkg::CSR_INDEX_W-1:0]          csr_index,
   input  logic [kap_pkg::CSR_DATA_W-1:0]           csr_write_data,
   output logic [NUM_CODES-1:0][kap_pkg::CODE_W-1:0] codes,
   output kap_pkg::delay_cfg_type                   delays
);

   logic [NUM_CODES-1:0][kap_pkg::CODE_W-1:0] code_ff;
   kap_pkg::delay_cfg_type                    delay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff              <= '0;
         delay_ff.arm_ticks   <= kap_pkg::DELAY_RESET;
         delay_ff.entry_ticks <= kap_pkg::DELAY_RESET;
      end else if (csr_write_enable) begin
         for (int i = 0; i < NUM_CODES; i++) begin
            if (csr_index == kap_pkg::CSR_INDEX_W'(i)) begin
               code_ff[i] <= csr_write_data;
            end
         end
         if (csr_index == kap_pkg::CSR_ARM_DELAY) begin
            delay_ff.arm_ticks <= csr_write_data[kap_pkg::TICK_W-1:0];
         end
         if (csr_index == kap_pkg::CSR_ENTRY_DELAY) begin
            delay_ff.entry_ticks <= csr_write_data[kap_pkg::TICK_W-1:0];
         end
      end
   end

   assign codes  = code_ff;
   assign delays = delay_ff;

endmodule

// ===== design/kap_seq.sv =====
// Panel sequencer: mode, countdown, code entry and blink state with its update logic.
module kap_seq #(
   parameter int NUM_CODES = 4
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     step_en,
   input  logic [kap_pkg::OP_W-1:0]                 op,
   input  logic [kap_pkg::KEY_W-1:0]                key_code,
   input  logic [kap_pkg::SW_W-1:0]                 switch_status,
   input  logic [NUM_CODES-1:0][kap_pkg::CODE_W-1:0] codes,
   input  kap_pkg::delay_cfg_type                   delays,
   output kap_pkg::result_type                      result
);

   kap_pkg::mode_type                mode_ff, mode_in;
   logic [kap_pkg::TICK_W-1:0]       count_ff, count_in;
   logic [kap_pkg::SEC_W-1:0]        shown_ff, shown_in;
   logic [kap_pkg::CODE_W-1:0]       acc_ff, acc_in;
   logic [kap_pkg::DIGIT_CNT_W-1:0]  digits_ff, digits_in;
   logic [kap_pkg::BLINK_W-1:0]      blink_ff, blink_in;
   logic                             lamp_ff, lamp_in;
   logic                             accepted;

   logic                             is_digit;
   logic [kap_pkg::KEY_W-1:0]        key_offset;
   logic [kap_pkg::CODE_W-1:0]       acc_sum;
   logic                             code_match;
   logic [kap_pkg::TICK_W-1:0]       count_dec;
   logic [kap_pkg::BLINK_W-1:0]      blink_inc;

   always_comb begin
      is_digit   = (key_code >= kap_pkg::KEY_ZERO) && (key_code <= kap_pkg::KEY_NINE);
      key_offset = key_code - kap_pkg::KEY_ZERO;
      acc_sum    = acc_ff + kap_pkg::digit_value(digits_ff, key_offset[3:0]);
      code_match = 1'b0;
      for (int i = 0; i < NUM_CODES; i++) begin
         if (codes[i] == acc_sum) begin
            code_match = 1'b1;
         end
      end
      count_dec = (count_ff != '0) ? count_ff - 8'd1 : count_ff;
      blink_inc = blink_ff + 4'd1;
   end

   // Next state.
   always_comb begin
      mode_in   = mode_ff;
      count_in  = count_ff;
      shown_in  = shown_ff;
      acc_in    = acc_ff;
      digits_in = digits_ff;
      blink_in  = blink_ff;
      lamp_in   = lamp_ff;
      accepted  = 1'b0;
      case (op)
         kap_pkg::OP_KEY: begin
            if (is_digit) begin
               if (digits_ff == kap_pkg::LAST_DIGIT) begin
                  accepted  = code_match;
                  acc_in    = '0;
                  digits_in = '0;
               end else begin
                  acc_in    = acc_sum;
                  digits_in = digits_ff + 2'd1;
               end
            end else if (mode_ff == kap_pkg::MODE_IDLE || key_code == kap_pkg::KEY_HASH) begin
               acc_in    = '0;
               digits_in = '0;
            end
            if (accepted) begin
               if (mode_ff == kap_pkg::MODE_IDLE) begin
                  if (delays.arm_ticks == '0) begin
                     mode_in  = kap_pkg::MODE_ARMED;
                     count_in = '0;
                     shown_in = '0;
                  end else begin
                     mode_in  = kap_pkg::MODE_ARMING;
                     count_in = delays.arm_ticks;
                     shown_in = kap_pkg::div10(delays.arm_ticks);
                  end
               end else begin
                  mode_in  = kap_pkg::MODE_IDLE;
                  count_in = '0;
                  shown_in = '0;
                  blink_in = '0;
                  lamp_in  = 1'b0;
               end
            end
         end
         kap_pkg::OP_TICK: begin
            if (mode_ff == kap_pkg::MODE_ARMING || mode_ff == kap_pkg::MODE_ENTRY) begin
               count_in = count_dec;
               if (kap_pkg::multiple_of_ten(count_dec)) begin
                  shown_in = kap_pkg::div10(count_dec);
               end
               if (count_dec == '0) begin
                  shown_in = '0;
                  if (mode_ff == kap_pkg::MODE_ARMING) begin
                     mode_in = kap_pkg::MODE_ARMED;
                  end else begin
                     mode_in  = kap_pkg::MODE_ALARM;
                     blink_in = '0;
                     lamp_in  = 1'b1;
                  end
               end
            end else if (mode_ff == kap_pkg::MODE_ALARM) begin
               if (blink_inc >= kap_pkg::BLINK_PERIOD) begin
                  blink_in = '0;
                  lamp_in  = ~lamp_ff;
               end else begin
                  blink_in = blink_inc;
               end
            end
         end
         kap_pkg::OP_SWITCH: begin
            if (mode_ff == kap_pkg::MODE_ARMED) begin
               if ((switch_status & kap_pkg::FRONT_DOOR_MASK) != '0) begin
                  if (delays.entry_ticks == '0) begin
                     mode_in  = kap_pkg::MODE_ALARM;
                     count_in = '0;
                     shown_in = '0;
                     blink_in = '0;
                     lamp_in  = 1'b1;
                  end else begin
                     mode_in  = kap_pkg::MODE_ENTRY;
                     count_in = delays.entry_ticks;
                     shown_in = kap_pkg::div10(delays.entry_ticks);
                  end
               end else if ((switch_status & kap_pkg::OTHER_SWITCH_MASK) != '0) begin
                  mode_in  = kap_pkg::MODE_ALARM;
                  count_in = '0;
                  shown_in = '0;
                  blink_in = '0;
                  lamp_in  = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Outputs: the state after this item.
   always_comb begin
      result.mode            = mode_in;
      result.countdown_shown = (mode_in == kap_pkg::MODE_ARMING) ||
                               (mode_in == kap_pkg::MODE_ENTRY);
      result.seconds_left    = result.countdown_shown ? shown_in : '0;
      result.alarm_lamp      = (mode_in == kap_pkg::MODE_ALARM) && lamp_in;
      result.code_accepted   = accepted;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= kap_pkg::MODE_IDLE;
         count_ff  <= '0;
         shown_ff  <= '0;
         acc_ff    <= '0;
         digits_ff <= '0;
         blink_ff  <= '0;
         lamp_ff   <= 1'b0;
      end else if (step_en) begin
         mode_ff   <= mode_in;
         count_ff  <= count_in;
         shown_ff  <= shown_in;
         acc_ff    <= acc_in;
         digits_ff <= digits_in;
         blink_ff  <= blink_in;
         lamp_ff   <= lamp_in;
      end
   end

endmodule

// ===== design/keypad_alarm_panel_controller_top.sv =====
// Top level of the keypad alarm panel controller.
//
// Items on the req_ channel are events: a key press, a 100 ms tick or a switch
// sample. Each item produces exactly one rsp_ item that reports the panel state
// after the event: mode, countdown digits, alarm lamp and whether the event
// completed a valid code. Both channels use valid/ready handshakes.
//
// An accepted item is held in an input register; once the output register is free
// or being drained, the state update runs and the result is written into the
// output register, which drives rsp_valid. One item per cycle is sustained while
// the receiver keeps rsp_ready high: the single update step between the two
// registers sets the rate.
// While the receiver stalls, the result stays in the output register and one
// more item waits in the input register; req_ready then drops.
//
// The csr_ port writes the valid codes (indexes 0 to 3) and the arming and entry
// countdown lengths (indexes 4 and 5); the user must write them only while the
// panel is quiet, which the block does not enforce. Reset clears the codes, sets
// both countdowns to 100 ticks and idles the panel: code entry empty, no item pending.
module keypad_alarm_panel_controller_top #(
   parameter int NUM_CODES = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [kap_pkg::OP_W-1:0]         req_op,
   input  logic [kap_pkg::KEY_W-1:0]        req_key_code,
   input  logic [kap_pkg::SW_W-1:0]         req_switch_status,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [2:0]                       rsp_mode,
   output logic [kap_pkg::SEC_W-1:0]        rsp_seconds_left,
   output logic                             rsp_countdown_shown,
   output logic                             rsp_alarm_lamp,
   output logic                             rsp_code_accepted,
   input  logic                             csr_write_enable,
   input  logic [kap_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [kap_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   logic                              in_valid_ff;
   logic [kap_pkg::OP_W-1:0]          in_op_ff;
   logic [kap_pkg::KEY_W-1:0]         in_key_ff;
   logic [kap_pkg::SW_W-1:0]          in_sw_ff;
   logic                              out_valid_ff;
   kap_pkg::result_type               out_ff;
   kap_pkg::result_type               result;
   logic                              advance;

   logic [NUM_CODES-1:0][kap_pkg::CODE_W-1:0] codes;
   kap_pkg::delay_cfg_type                    delays;

   // The held item moves on whenever the output register is free or being drained.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   kap_cfg #(
      .NUM_CODES (NUM_CODES)
   ) u_cfg (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .codes            (codes),
      .delays           (delays)
   );

   kap_seq #(
      .NUM_CODES (NUM_CODES)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .step_en       (advance),
      .op            (in_op_ff),
      .key_code      (in_key_ff),
      .switch_status (in_sw_ff),
      .codes         (codes),
      .delays        (delays),
      .result        (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_op_ff  <= req_op;
         in_key_ff <= req_key_code;
         in_sw_ff  <= req_switch_status;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_mode            = out_ff.mode;
   assign rsp_seconds_left    = out_ff.seconds_left;
   assign rsp_countdown_shown = out_ff.countdown_shown;
   assign rsp_alarm_lamp      = out_ff.alarm_lamp;
   assign rsp_code_accepted   = out_ff.code_accepted;

   // A pending item that cannot move on is still there next cycle.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("pending item lost from input register");

   // Countdown digits are shown exactly in the two countdown modes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_countdown_shown ==
         (rsp_mode == kap_pkg::MODE_ARMING || rsp_mode == kap_pkg::MODE_ENTRY)))
      else $error("countdown display disagrees with mode");

   // The lamp is only ever lit in alarm mode.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_alarm_lamp |-> rsp_mode == kap_pkg::MODE_ALARM)
      else $error("alarm lamp lit outside alarm mode");

   // A valid code always leaves the panel idle, arming or armed.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_code_accepted |->
         (rsp_mode == kap_pkg::MODE_IDLE || rsp_mode == kap_pkg::MODE_ARMING ||
          rsp_mode == kap_pkg::MODE_ARMED))
      else $error("accepted code left panel in wrong mode");

endmodule

// ===== tb/sv/kap_tb_pkg.sv =====
// Scoreboard and shared constants for the keypad alarm panel controller testbench.
`timescale 1ns / 1ps

package kap_tb_pkg;
   import kap_pkg::*;

   localparam int PANEL_CODES = 4;

   localparam logic [CSR_INDEX_W-1:0] REG_CODE_ZERO  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CODE_ONE   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CODE_TWO   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_CODE_THREE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_LOW  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_HIGH = 3'd7;

   localparam logic [OP_W-1:0]  OP_SPARE     = 2'd3;
   localparam logic [KEY_W-1:0] KEY_LETTER_A = 8'h41;

   class panel_scoreboard;
      logic [CODE_W-1:0]      valid_code [PANEL_CODES];
      logic [TICK_W-1:0]      arm_ticks;
      logic [TICK_W-1:0]      entry_ticks;

      mode_type               mode_now;
      logic [TICK_W-1:0]      delay_left;
      logic [SEC_W-1:0]       secs_shown;
      logic [CODE_W-1:0]      code_sum;
      logic [DIGIT_CNT_W-1:0] digits_in;
      logic [BLINK_W-1:0]     blink_count;
      logic                   lamp_lit;

      result_type             expected_panel[$];
      int                     error_count;
      int                     checked_count;
      int                     codes_taken;
      int                     alarms_raised;

      function new();
         foreach (valid_code[i]) valid_code[i] = '0;
         arm_ticks     = DELAY_RESET;
         entry_ticks   = DELAY_RESET;
         code_sum      = '0;
         digits_in     = '0;
         error_count   = 0;
         checked_count = 0;
         codes_taken   = 0;
         alarms_raised = 0;
         go_idle();
      endfunction

      function void set_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx <= REG_CODE_THREE) begin
            valid_code[idx] = data;
         end else if (idx == CSR_ARM_DELAY) begin
            arm_ticks = data[TICK_W-1:0];
         end else if (idx == CSR_ENTRY_DELAY) begin
            entry_ticks = data[TICK_W-1:0];
         end
      endfunction

      function void go_idle();
         mode_now    = MODE_IDLE;
         delay_left  = '0;
         secs_shown  = '0;
         blink_count = '0;
         lamp_lit    = 1'b0;
      endfunction

      function void go_alarm();
         if (mode_now != MODE_ALARM) alarms_raised++;
         mode_now    = MODE_ALARM;
         delay_left  = '0;
         secs_shown  = '0;
         blink_count = '0;
         lamp_lit    = 1'b1;
      endfunction

      function void start_countdown(mode_type next_mode, logic [TICK_W-1:0] ticks);
         mode_now   = next_mode;
         delay_left = ticks;
         secs_shown = SEC_W'(ticks / 8'd10);
      endfunction

      // Returns 1 when the key completes a code that matches a register.
      function bit take_key(logic [KEY_W-1:0] key);
         bit hit;
         int weight;
         hit = 1'b0;
         if (key >= KEY_ZERO && key <= KEY_NINE) begin
            weight = 1000;
            for (int k = 0; k < int'(digits_in); k++) weight = weight / 10;
            code_sum = code_sum + CODE_W'(int'(key - KEY_ZERO) * weight);
            if (digits_in == LAST_DIGIT) begin
               for (int i = 0; i < PANEL_CODES; i++) begin
                  if (valid_code[i] == code_sum) hit = 1'b1;
               end
               code_sum  = '0;
               digits_in = '0;
            end else begin
               digits_in = digits_in + 1'b1;
            end
         end else if (mode_now == MODE_IDLE || key == KEY_HASH) begin
            code_sum  = '0;
            digits_in = '0;
         end
         return hit;
      endfunction

      function void take_tick();
         if (mode_now == MODE_ARMING || mode_now == MODE_ENTRY) begin
            if (delay_left != 0) delay_left = delay_left - 1'b1;
            if (delay_left % 10 == 0) secs_shown = SEC_W'(delay_left / 8'd10);
            if (delay_left == 0) begin
               if (mode_now == MODE_ARMING) begin
                  mode_now   = MODE_ARMED;
                  secs_shown = '0;
               end else begin
                  go_alarm();
               end
            end
         end else if (mode_now == MODE_ALARM) begin
            blink_count = blink_count + 1'b1;
            if (blink_count >= BLINK_PERIOD) begin
               blink_count = '0;
               lamp_lit    = ~lamp_lit;
            end
         end
      endfunction

      // Applies one event to the panel state and returns the expected result.
      function result_type advance_panel(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                         logic [SW_W-1:0] sw);
         result_type r;
         bit         hit;
         bit         counting;
         hit = 1'b0;
         case (op)
            OP_KEY: begin
               hit = take_key(key);
               if (hit) begin
                  codes_taken++;
                  if (mode_now == MODE_IDLE) begin
                     if (arm_ticks == 0) begin
                        mode_now   = MODE_ARMED;
                        delay_left = '0;
                        secs_shown = '0;
                     end else begin
                        start_countdown(MODE_ARMING, arm_ticks);
                     end
                  end else begin
                     go_idle();
                  end
               end
            end
            OP_TICK: take_tick();
            OP_SWITCH: begin
               if (mode_now == MODE_ARMED) begin
                  if ((sw & FRONT_DOOR_MASK) != 0) begin
                     if (entry_ticks == 0) go_alarm();
                     else start_countdown(MODE_ENTRY, entry_ticks);
                  end else if ((sw & OTHER_SWITCH_MASK) != 0) begin
                     go_alarm();
                  end
               end
            end
            default: ;
         endcase
         counting          = (mode_now == MODE_ARMING || mode_now == MODE_ENTRY);
         r.mode            = mode_now;
         r.seconds_left    = counting ? secs_shown : '0;
         r.countdown_shown = counting;
         r.alarm_lamp      = (mode_now == MODE_ALARM) ? lamp_lit : 1'b0;
         r.code_accepted   = hit;
         return r;
      endfunction

      function void note_event(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                               logic [SW_W-1:0] sw);
         expected_panel.push_back(advance_panel(op, key, sw));
      endfunction

      function int pending();
         return expected_panel.size();
      endfunction

      task report(string what);
         if (error_count < 40) $display("ERROR: %s", what);
         error_count++;
      endtask

      task check_result(result_type got);
         result_type want;
         if (expected_panel.size() == 0) begin
            report("result arrived with no event waiting for it");
         end else begin
            want = expected_panel.pop_front();
            checked_count++;
            if (got.mode != want.mode)
               report($sformatf("result %0d: mode %0d, expected %0d",
                                checked_count, got.mode, want.mode));
            if (got.seconds_left != want.seconds_left)
               report($sformatf("result %0d: seconds_left %0d, expected %0d",
                                checked_count, got.seconds_left, want.seconds_left));
            if (got.countdown_shown != want.countdown_shown)
               report($sformatf("result %0d: countdown_shown %0b, expected %0b",
                                checked_count, got.countdown_shown, want.countdown_shown));
            if (got.alarm_lamp != want.alarm_lamp)
               report($sformatf("result %0d: alarm_lamp %0b, expected %0b",
                                checked_count, got.alarm_lamp, want.alarm_lamp));
            if (got.code_accepted != want.code_accepted)
               report($sformatf("result %0d: code_accepted %0b, expected %0b",
                                checked_count, got.code_accepted, want.code_accepted));
         end
      endtask
   endclass

endpackage

// ===== tb/sv/tb_top.sv =====
// Testbench top for the keypad alarm panel controller: clock, stimulus, port monitor.
`timescale 1ns / 1ps

module tb_top;
   import kap_pkg::*;
   import kap_tb_pkg::*;

   localparam int QUIET_LIMIT   = 1000;
   localparam int LONG_HOLD     = 120;
   localparam int SETTLE_CYCLES = 6;
   localparam int NUM_PHASES    = 8;
   localparam int PHASE_ITEMS   = 205;

   typedef enum int {SINK_OPEN, SINK_COIN, SINK_EVERY_NTH, SINK_MOSTLY} sink_style_type;

   logic                   clock;
   logic                   reset             = 1'b1;
   logic                   req_valid         = 1'b0;
   logic                   req_ready;
   logic [OP_W-1:0]        req_op            = OP_KEY;
   logic [KEY_W-1:0]       req_key_code      = '0;
   logic [SW_W-1:0]        req_switch_status = '0;
   logic                   rsp_valid;
   logic                   rsp_ready         = 1'b0;
   logic [2:0]             rsp_mode;
   logic [SEC_W-1:0]       rsp_seconds_left;
   logic                   rsp_countdown_shown;
   logic                   rsp_alarm_lamp;
   logic                   rsp_code_accepted;
   logic                   csr_write_enable  = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index         = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data    = '0;

   panel_scoreboard        panel_sb;
   logic [CODE_W-1:0]      cur_code [PANEL_CODES];
   int                     hold_asks   = 0;
   int                     quiet_cycles = 0;
   int                     items_sent  = 0;
   int                     burst_left  = 0;
   bit                     no_gaps     = 1'b0;

   keypad_alarm_panel_controller_top #(.NUM_CODES(PANEL_CODES)) u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_key_code        (req_key_code),
      .req_switch_status   (req_switch_status),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_mode            (rsp_mode),
      .rsp_seconds_left    (rsp_seconds_left),
      .rsp_countdown_shown (rsp_countdown_shown),
      .rsp_alarm_lamp      (rsp_alarm_lamp),
      .rsp_code_accepted   (rsp_code_accepted),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Results are checked before the same edge's accepted event is noted; an event
   // never produces its result on the edge that accepts it.
   always @(posedge clock) begin : watch_ports
      result_type seen;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            seen.mode            = mode_type'(rsp_mode);
            seen.seconds_left    = rsp_seconds_left;
            seen.countdown_shown = rsp_countdown_shown;
            seen.alarm_lamp      = rsp_alarm_lamp;
            seen.code_accepted   = rsp_code_accepted;
            panel_sb.check_result(seen);
         end
         if (req_valid && req_ready)
            panel_sb.note_event(req_op, req_key_code, req_switch_status);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles, %0d results still expected",
                  QUIET_LIMIT, panel_sb.pending());
         $display("tb_top: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result side: changes its stall style every stretch, and holds off for a long
   // run whenever the stimulus asks for one.
   initial begin : result_sink
      sink_style_type style;
      int stretch;
      int period;
      int beat;
      int hold_left;
      int served;
      style     = SINK_OPEN;
      stretch   = 0;
      period    = 2;
      beat      = 0;
      hold_left = 0;
      served    = 0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && served != hold_asks) begin
            served++;
            hold_left = LONG_HOLD;
         end
         if (stretch == 0) begin
            style   = sink_style_type'($urandom_range(0, 3));
            stretch = $urandom_range(5, 60);
            period  = $urandom_range(2, 6);
         end
         stretch--;
         beat++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (style)
               SINK_OPEN:      rsp_ready <= 1'b1;
               SINK_COIN:      rsp_ready <= 1'($urandom_range(0, 1));
               SINK_EVERY_NTH: rsp_ready <= (beat % period == 0);
               default:        rsp_ready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_index        <= idx;
      csr_write_data   <= data;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      panel_sb.set_reg(idx, data);
      if (idx <= REG_CODE_THREE) cur_code[idx] = data;
   endtask

   // Offers one event and waits for it to be taken; bursts end in a random gap.
   task automatic offer(logic [OP_W-1:0] op, logic [KEY_W-1:0] key, logic [SW_W-1:0] sw);
      req_op            <= op;
      req_key_code      <= key;
      req_switch_status <= sw;
      req_valid         <= 1'b1;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0 && !no_gaps) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 10);
      end
   endtask

   task automatic press(logic [KEY_W-1:0] key);
      offer(OP_KEY, key, SW_W'($urandom));
   endtask

   task automatic tick_n(int n);
      repeat (n) offer(OP_TICK, KEY_W'($urandom), SW_W'($urandom));
   endtask

   task automatic sample_switches(logic [SW_W-1:0] sw);
      offer(OP_SWITCH, KEY_W'($urandom), sw);
   endtask

   function automatic logic [KEY_W-1:0] noise_key();
      logic [KEY_W-1:0] k;
      case ($urandom_range(0, 3))
         0:       k = KEY_HASH;
         1:       k = KEY_LETTER_A;
         default: begin
            do k = KEY_W'($urandom); while (k >= KEY_ZERO && k <= KEY_NINE);
         end
      endcase
      return k;
   endfunction

   function automatic logic [SW_W-1:0] pick_switches();
      logic [SW_W-1:0] sw;
      case ($urandom_range(0, 6))
         0, 1, 2: sw = FRONT_DOOR_MASK | (SW_W'($urandom) & OTHER_SWITCH_MASK);
         3, 4:    sw = SW_W'(1) << $urandom_range(1, 7);
         5:       sw = '0;
         default: sw = SW_W'($urandom);
      endcase
      return sw;
   endfunction

   // Types the four digits of a value; a broken entry slips a stray key in.
   task automatic type_code(logic [CODE_W-1:0] val, bit broken);
      int place;
      int slip;
      place = 1000;
      slip  = $urandom_range(0, 3);
      for (int p = 0; p < 4; p++) begin
         if (broken && p == slip) press(noise_key());
         press(KEY_ZERO + KEY_W'((int'(val) / place) % 10));
         place = place / 10;
      end
   endtask

   // The first edge lets the monitor note an item taken at the edge just passed.
   task automatic settle();
      req_valid  <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (panel_sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_panel_traffic(int budget);
      int start;
      int pick;
      start = items_sent;
      while (items_sent - start < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            type_code(cur_code[$urandom_range(0, PANEL_CODES - 1)],
                      $urandom_range(0, 6) == 0);
         end else if (pick < 45) begin
            type_code(CODE_W'($urandom_range(0, 9999)), 1'b0);
         end else if (pick < 65) begin
            if ($urandom_range(0, 9) == 0) tick_n($urandom_range(20, 260));
            else tick_n($urandom_range(1, 12));
         end else if (pick < 80) begin
            sample_switches(pick_switches());
         end else if (pick < 88) begin
            press(($urandom_range(0, 1) == 0) ? noise_key() : KEY_W'($urandom));
         end else if (pick < 93) begin
            offer(OP_SPARE, KEY_W'($urandom), SW_W'($urandom));
         end else begin
            repeat ($urandom_range(1, 3)) press(KEY_ZERO + KEY_W'($urandom_range(0, 9)));
         end
      end
   endtask

   task automatic configure_phase(int phase);
      logic [CODE_W-1:0] code_set [PANEL_CODES];
      logic [TICK_W-1:0] arm;
      logic [TICK_W-1:0] entry;
      foreach (code_set[i]) code_set[i] = CODE_W'($urandom_range(0, 9999));
      case (phase)
         0: begin arm = 8'd0;   entry = 8'd0;   end
         1: begin arm = 8'd1;   entry = 8'd1;   end
         2: begin arm = 8'd255; entry = 8'd255; end
         3: begin arm = 8'd10;  entry = 8'd20;  end
         default: begin
            arm   = ($urandom_range(0, 3) == 0) ? TICK_W'($urandom)
                                                : TICK_W'($urandom_range(1, 30));
            entry = ($urandom_range(0, 3) == 0) ? TICK_W'($urandom)
                                                : TICK_W'($urandom_range(1, 30));
         end
      endcase
      if (phase == 1) begin
         code_set[0] = '0;
         code_set[3] = CODE_W'(9999);
      end
      if (phase == 3) code_set[2] = '1;
      for (int i = 0; i < PANEL_CODES; i++)
         write_reg(CSR_INDEX_W'(REG_CODE_ZERO + i), code_set[i]);
      write_reg(CSR_ARM_DELAY, CSR_DATA_W'(arm));
      write_reg(CSR_ENTRY_DELAY, CSR_DATA_W'(entry));
      if (phase == 4) write_reg(REG_SPARE_HIGH, CSR_DATA_W'($urandom));
   endtask

   initial begin : stimulus
      panel_sb = new();
      foreach (cur_code[i]) cur_code[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_reg(REG_CODE_ZERO, CODE_W'(1234));
      write_reg(REG_CODE_ONE, '0);
      write_reg(REG_CODE_TWO, CODE_W'(9999));
      write_reg(REG_CODE_THREE, '1);
      write_reg(CSR_ARM_DELAY, CSR_DATA_W'(2));
      write_reg(CSR_ENTRY_DELAY, CSR_DATA_W'(1));
      write_reg(REG_SPARE_LOW, '1);
      write_reg(REG_SPARE_HIGH, CSR_DATA_W'(5));

      // Short walk through every mode: unused op, clearing keys in idle, arming,
      // front door entry, alarm, then a disarm that only works because '#'
      // cleared the partial code and the letter key was ignored.
      offer(OP_SPARE, 8'hFF, 8'hFF);
      press(8'h00);
      press(KEY_ZERO + 8'd1);
      press(KEY_ZERO + 8'd2);
      press(8'hFF);
      type_code(CODE_W'(1234), 1'b0);
      tick_n(2);
      sample_switches(8'h00);
      sample_switches(FRONT_DOOR_MASK);
      tick_n(1);
      sample_switches(OTHER_SWITCH_MASK);
      press(KEY_ZERO + 8'd5);
      press(KEY_HASH);
      press(KEY_NINE);
      press(KEY_NINE);
      press(KEY_LETTER_A);
      press(KEY_NINE);
      press(KEY_NINE);
      settle();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         configure_phase(phase);
         if (phase == 2) begin
            // Stall the result side while events keep coming, so the block backs up.
            hold_asks <= hold_asks + 1;
            no_gaps = 1'b1;
            repeat (30) begin
               if ($urandom_range(0, 1) == 0) tick_n(1);
               else press(KEY_ZERO + KEY_W'($urandom_range(0, 9)));
            end
            no_gaps = 1'b0;
         end
         run_panel_traffic(PHASE_ITEMS);
         settle();
      end

      $display("Sent %0d events over %0d register settings and checked %0d results.",
               items_sent, NUM_PHASES + 1, panel_sb.checked_count);
      $display("Valid codes taken: %0d, alarm entries: %0d.",
               panel_sb.codes_taken, panel_sb.alarms_raised);
      if (panel_sb.error_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("%0d mismatches", panel_sb.error_count);
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
